// File: hw/rtl/crc16_configurable_stream_core_assert.svh
// Assertion macros for the configurable CRC-16 stream core.
`ifndef CRC16_CONFIGURABLE_STREAM_CORE_ASSERT_SVH
`define CRC16_CONFIGURABLE_STREAM_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define CRC16CS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc16cs same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define CRC16CS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc16cs next-cycle check failed");

`endif

// File: hw/rtl/crc16cs_pkg.sv
// Shared constants, types and bit-reversal helpers for the CRC-16 stream core.
package crc16cs_pkg;

  localparam int unsigned CRC_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned REG_IDX_W = 3;

  // Default register values
  localparam logic [CRC_W-1:0] POLY_RST = 16'h1021;
  localparam logic [CRC_W-1:0] INIT_RST = 16'hFFFF;
  localparam logic [CRC_W-1:0] XOR_RST  = 16'h0000;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_POLYNOMIAL       = 3'd0,
    REG_INITIAL_VALUE    = 3'd1,
    REG_FINAL_XOR_VALUE  = 3'd2,
    REG_REFLECT_INPUT    = 3'd3,
    REG_REFLECT_OUTPUT   = 3'd4,
    REG_FINAL_XOR_ENABLE = 3'd5
  } reg_idx_t;

  // Settings that the byte divider needs
  typedef struct packed {
    logic [CRC_W-1:0] polynomial;
    logic             reflect_input;
  } div_cfg_t;

  // Reverse the bit order of a byte
  function automatic logic [BYTE_W-1:0] rev_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

  // Reverse the bit order of a CRC word
  function automatic logic [CRC_W-1:0] rev_crc(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/crc16_configurable_stream_core.sv
// Result: a result appears in out_valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the eight-step divider sits between the remainder
// register and the input port. A last byte waits only while an earlier result is held.
// Reset (synchronous, rst_n low): configuration registers take their defaults, no result pending,
// and the next byte starts a message.
module crc16_configurable_stream_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // byte input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [crc16cs_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                                 in_last_byte,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [crc16cs_pkg::CRC_W-1:0]        out_crc_value,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [crc16cs_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [crc16cs_pkg::CRC_W-1:0]        cfg_wdata
);

  `include "crc16_configurable_stream_core_assert.svh"

  // Configuration registers
  logic [crc16cs_pkg::CRC_W-1:0] poly_r;
  logic [crc16cs_pkg::CRC_W-1:0] init_r;
  logic [crc16cs_pkg::CRC_W-1:0] xor_val_r;
  logic                          refl_in_r;
  logic                          refl_out_r;
  logic                          xor_en_r;

  // Running state and result stage
  logic [crc16cs_pkg::CRC_W-1:0] rem_r, rem_nxt;
  logic                          at_start_r;
  logic                          out_valid_r;
  logic [crc16cs_pkg::CRC_W-1:0] out_crc_r, out_crc_nxt;

  logic                          in_fire;
  logic [crc16cs_pkg::CRC_W-1:0] rem_base;
  logic [crc16cs_pkg::CRC_W-1:0] rem_refl;
  crc16cs_pkg::div_cfg_t         div_cfg;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r     <= crc16cs_pkg::POLY_RST;
      init_r     <= crc16cs_pkg::INIT_RST;
      xor_val_r  <= crc16cs_pkg::XOR_RST;
      refl_in_r  <= 1'b0;
      refl_out_r <= 1'b0;
      xor_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (crc16cs_pkg::reg_idx_t'(cfg_index))
        crc16cs_pkg::REG_POLYNOMIAL:       poly_r     <= cfg_wdata;
        crc16cs_pkg::REG_INITIAL_VALUE:    init_r     <= cfg_wdata;
        crc16cs_pkg::REG_FINAL_XOR_VALUE:  xor_val_r  <= cfg_wdata;
        crc16cs_pkg::REG_REFLECT_INPUT:    refl_in_r  <= cfg_wdata[0];
        crc16cs_pkg::REG_REFLECT_OUTPUT:   refl_out_r <= cfg_wdata[0];
        crc16cs_pkg::REG_FINAL_XOR_ENABLE: xor_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Accept non-last items always; a last item needs a free result slot
  assign in_ready = !out_valid_r || out_ready || !in_last_byte;
  assign in_fire  = in_valid && in_ready;

  // Start from the initial value at a message boundary
  assign rem_base = at_start_r ? init_r : rem_r;

  assign div_cfg.polynomial    = poly_r;
  assign div_cfg.reflect_input = refl_in_r;

  crc16cs_byte_div u_byte_div (
    .crc_in    (rem_base),
    .data_byte (in_data_byte),
    .cfg       (div_cfg),
    .crc_out   (rem_nxt)
  );

  // Finish the CRC: reflect, then XOR
  assign rem_refl    = refl_out_r ? crc16cs_pkg::rev_crc(rem_nxt) : rem_nxt;
  assign out_crc_nxt = xor_en_r ? (rem_refl ^ xor_val_r) : rem_refl;

  // Advance remainder and message-start flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      at_start_r <= 1'b1;
    end else if (in_fire) begin
      rem_r      <= rem_nxt;
      at_start_r <= in_last_byte;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      out_crc_r <= out_crc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  // A last item always yields a pending result next cycle
  `CRC16CS_ASSERT_NEXT(a_last_gives_result, in_fire && in_last_byte, out_valid_r)
  // A last item restarts the message
  `CRC16CS_ASSERT_NEXT(a_last_restarts, in_fire && in_last_byte, at_start_r)
  // Never overwrite a result that is still held
  `CRC16CS_ASSERT_SAME(a_no_overwrite, out_valid_r && !out_ready, !(in_fire && in_last_byte))

endmodule

// File: hw/rtl/crc16cs_byte_div.sv
// One-byte CRC-16 update: optional input reflection, then eight XOR-shift steps.
module crc16cs_byte_div (
  input  logic [crc16cs_pkg::CRC_W-1:0]  crc_in,
  input  logic [crc16cs_pkg::BYTE_W-1:0] data_byte,
  input  crc16cs_pkg::div_cfg_t          cfg,
  output logic [crc16cs_pkg::CRC_W-1:0]  crc_out
);

  logic [crc16cs_pkg::BYTE_W-1:0] msg_byte;
  logic [crc16cs_pkg::CRC_W-1:0]  rem;

  // Reflect the byte when asked
  assign msg_byte = cfg.reflect_input ? crc16cs_pkg::rev_byte(data_byte) : data_byte;

  // Divide MSB-first, one bit per step
  always_comb begin
    rem = crc_in ^ {msg_byte, {(crc16cs_pkg::CRC_W - crc16cs_pkg::BYTE_W){1'b0}}};
    for (int i = 0; i < crc16cs_pkg::BYTE_W; i++) begin
      if (rem[crc16cs_pkg::CRC_W-1]) begin
        rem = (rem << 1) ^ cfg.polynomial;
      end else begin
        rem = rem << 1;
      end
    end
  end

  assign crc_out = rem;

endmodule
